>>> rtl/cdt_pkg.sv
// Shared types and opcode constants for the countdown timer bank.
package cdt_pkg;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 3;
    localparam int PERIOD_W = 32;

    typedef logic [OPCODE_W-1:0] t_opcode;

    localparam t_opcode OP_TICK  = 2'd0;
    localparam t_opcode OP_START = 2'd1;
    localparam t_opcode OP_CHECK = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_RELOAD
    } t_state;

endpackage

>>> rtl/countdown_timer_bank.sv
// Countdown timer bank: a set of one-shot or periodic timers advanced by tick transfers.
//
// The input channel (i_valid, o_stall) carries one command per transfer: a tick,
// a start of one timer or a check of one timer. The output channel (o_valid,
// i_stall) carries one expired bit for every check, and nothing for other commands.
// A check of a periodic timer that has expired also reloads its counter, in a
// separate reload state. During a tick, one shared decrementer walks the counter
// memory, reading one timer and writing back the one before it in each cycle.
// The block accepts no command while a tick or a
// reload is in progress. The check result is registered and appears in the cycle
// after the transfer; it holds while i_stall is high, and no command of any kind
// is accepted while a result is held back. A new command may be accepted in the
// cycle in which the held result is taken.
// After reset all counters are idle at zero, all flags are clear
// and every timer is one-shot; valid bits make unwritten counter entries read as
// zero, so no clearing pass is needed.
module countdown_timer_bank
    import cdt_pkg::*;
#(
    parameter int NUM_TIMERS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [INDEX_W-1:0]  i_timer_index,
    input  logic [PERIOD_W-1:0] i_period_ticks,
    input  logic                i_periodic_mode,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_expired
);

    localparam int AW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int IXW = $clog2(NUM_TIMERS + 1);

    logic [PERIOD_W-1:0]   r_cnt_mem [NUM_TIMERS];
    logic [PERIOD_W-1:0]   r_rld_mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_cnt_vld;
    logic [NUM_TIMERS-1:0] r_flag;
    logic [NUM_TIMERS-1:0] r_mode;

    t_state              r_state, n_state;
    logic [IXW-1:0]      r_idx;
    logic                r_tk_vld;
    logic [AW-1:0]       r_tk_addr;
    logic [PERIOD_W-1:0] r_cnt_rd;
    logic                r_cnt_rd_vld;
    logic [PERIOD_W-1:0] r_rld_rd;
    logic [AW-1:0]       r_chk_addr;
    logic                r_o_valid;
    logic                r_o_expired;

    logic                in_acc;
    logic                idx_ok;
    logic [AW-1:0]       a_idx;
    logic                hit;
    logic                sweep_end;
    logic [PERIOD_W-1:0] cur_cnt;
    logic [PERIOD_W-1:0] dec_cnt;
    logic                cnt_we;
    logic [AW-1:0]       cnt_waddr;
    logic [PERIOD_W-1:0] cnt_wdata;
    logic                start_we;
    logic [PERIOD_W-1:0] start_period;
    logic                flag_set;
    logic                chk_acc;

    assign o_stall   = (r_state != S_IDLE) || (r_o_valid && i_stall);
    assign in_acc    = i_valid && !o_stall;
    assign idx_ok    = {{(32-INDEX_W){1'b0}}, i_timer_index} < 32'(NUM_TIMERS);
    assign a_idx     = AW'(i_timer_index);
    assign hit       = idx_ok && r_flag[a_idx];
    assign sweep_end = (r_idx == IXW'(NUM_TIMERS));
    assign cur_cnt   = r_cnt_rd_vld ? r_cnt_rd : '0;
    assign dec_cnt   = cur_cnt - PERIOD_W'(1);
    assign chk_acc   = in_acc && (i_opcode == OP_CHECK);
    assign start_period = (i_period_ticks == '0) ? PERIOD_W'(1) : i_period_ticks;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_opcode == OP_TICK)) begin
                    n_state = S_TICK;
                end else if (chk_acc && hit && r_mode[a_idx]) begin
                    n_state = S_RELOAD;
                end
            end
            S_TICK: begin
                if (sweep_end) begin
                    n_state = S_IDLE;
                end
            end
            S_RELOAD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_chk_addr;
        cnt_wdata = r_rld_rd;
        start_we  = 1'b0;
        flag_set  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_opcode == OP_START) && idx_ok) begin
                    start_we  = 1'b1;
                    cnt_we    = 1'b1;
                    cnt_waddr = a_idx;
                    cnt_wdata = start_period;
                end
            end
            S_TICK: begin
                if (r_tk_vld && (cur_cnt != '0)) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = r_tk_addr;
                    cnt_wdata = dec_cnt;
                    flag_set  = (dec_cnt == '0);
                end
            end
            S_RELOAD: begin
                cnt_we = 1'b1;
            end
            default: begin
                cnt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (start_we) begin
            r_rld_mem[a_idx] <= start_period;
        end
        if (r_idx < IXW'(NUM_TIMERS)) begin
            r_cnt_rd     <= r_cnt_mem[r_idx[AW-1:0]];
            r_cnt_rd_vld <= r_cnt_vld[r_idx[AW-1:0]];
        end
        if (idx_ok) begin
            r_rld_rd <= r_rld_mem[a_idx];
        end
        r_tk_addr <= r_idx[AW-1:0];
        if (chk_acc) begin
            r_chk_addr <= a_idx;
        end
        if (chk_acc) begin
            r_o_expired <= hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_tk_vld  <= 1'b0;
            r_cnt_vld <= '0;
            r_flag    <= '0;
            r_mode    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_TICK) begin
                r_tk_vld <= !sweep_end;
                if (!sweep_end) begin
                    r_idx <= r_idx + IXW'(1);
                end
            end else begin
                r_tk_vld <= 1'b0;
                r_idx    <= '0;
            end
            if (cnt_we) begin
                r_cnt_vld[cnt_waddr] <= 1'b1;
            end
            if (start_we) begin
                r_flag[a_idx] <= 1'b0;
                r_mode[a_idx] <= i_periodic_mode;
            end
            if (flag_set) begin
                r_flag[r_tk_addr] <= 1'b1;
            end
            if (chk_acc && hit) begin
                r_flag[a_idx] <= 1'b0;
            end
            if (chk_acc) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid   = r_o_valid;
    assign o_expired = r_o_expired;

endmodule

>>> tb/tb_countdown_timer_bank.sv
// Self-checking testbench for the countdown timer bank: directed table, then random commands.
module tb_countdown_timer_bank;
    timeunit 1ns;
    timeprecision 1ps;

    import cdt_pkg::*;

    localparam int      NUM_TIMERS  = 8;
    localparam int      RANDOM_CMDS = 650;
    localparam int      CYCLE_LIMIT = 200000;
    localparam int      HOLD_CYCLES = 300;
    localparam t_opcode OP_UNUSED   = 2'd3;

    typedef struct {
        t_opcode             op;
        logic [INDEX_W-1:0]  idx;
        logic [PERIOD_W-1:0] period;
        logic                mode;
        bit                  typed;
        bit                  typed_val;
    } t_cmd_row;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_valid         = 1'b0;
    logic                o_stall;
    logic [OPCODE_W-1:0] i_opcode        = '0;
    logic [INDEX_W-1:0]  i_timer_index   = '0;
    logic [PERIOD_W-1:0] i_period_ticks  = '0;
    logic                i_periodic_mode = 1'b0;
    logic                o_valid;
    logic                i_stall         = 1'b0;
    logic                o_expired;

    bit                  drv_typed       = 1'b0;
    bit                  drv_typed_val   = 1'b0;
    bit                  calm            = 1'b0;
    bit                  hold_request    = 1'b0;
    int                  hold_left       = 0;
    int                  error_count     = 0;
    int                  cycle_count     = 0;

    logic [PERIOD_W-1:0] counter_m [NUM_TIMERS];
    logic [PERIOD_W-1:0] reload_m  [NUM_TIMERS];
    logic                flag_m    [NUM_TIMERS];
    logic                periodic_m[NUM_TIMERS];
    bit                  expired_due_q[$];
    t_cmd_row            directed_rows[25];

    countdown_timer_bank #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_timer_index   (i_timer_index),
        .i_period_ticks  (i_period_ticks),
        .i_periodic_mode (i_periodic_mode),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_expired       (o_expired)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input bit got, input bit want);
        $display("[%0t] mismatch: %s (got %0b, want %0b)", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic apply_command(input t_opcode op, input logic [INDEX_W-1:0] idx,
                                 input logic [PERIOD_W-1:0] period, input logic mode,
                                 output bit produced, output bit hit);
        logic [PERIOD_W-1:0] load;
        produced = 1'b0;
        hit      = 1'b0;
        if (op == OP_TICK) begin
            for (int t = 0; t < NUM_TIMERS; t++) begin
                if (counter_m[t] != '0) begin
                    counter_m[t] = counter_m[t] - 1'b1;
                    if (counter_m[t] == '0) begin
                        flag_m[t] = 1'b1;
                    end
                end
            end
        end else if (op == OP_START) begin
            if (int'(idx) < NUM_TIMERS) begin
                load            = (period == '0) ? PERIOD_W'(1) : period;
                counter_m[idx]  = load;
                reload_m[idx]   = load;
                flag_m[idx]     = 1'b0;
                periodic_m[idx] = mode;
            end
        end else if (op == OP_CHECK) begin
            produced = 1'b1;
            if (int'(idx) < NUM_TIMERS && flag_m[idx]) begin
                hit         = 1'b1;
                flag_m[idx] = 1'b0;
                if (periodic_m[idx]) begin
                    counter_m[idx] = reload_m[idx];
                end
            end
        end
    endtask

    task automatic send_cmd(input t_opcode op, input logic [INDEX_W-1:0] idx,
                            input logic [PERIOD_W-1:0] period, input logic mode,
                            input bit typed, input bit typed_val);
        while (!calm && $urandom_range(0, 99) < 11) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_timer_index   <= idx;
        i_period_ticks  <= period;
        i_periodic_mode <= mode;
        drv_typed       <= typed;
        drv_typed_val   <= typed_val;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    always @(posedge i_clk) begin
        bit produced;
        bit hit;
        bit want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                apply_command(i_opcode, i_timer_index, i_period_ticks, i_periodic_mode,
                              produced, hit);
                if (produced) begin
                    expired_due_q.push_back(drv_typed ? drv_typed_val : hit);
                end
            end
            if (o_valid && !i_stall) begin
                if (expired_due_q.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding", o_expired, 1'b0);
                end else begin
                    want = expired_due_q.pop_front();
                    if (o_expired !== want) begin
                        report_mismatch("expired", o_expired, want);
                    end
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (calm) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < 11);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int                  sent;
        int                  roll;
        t_opcode             op;
        logic [PERIOD_W-1:0] period;

        for (int t = 0; t < NUM_TIMERS; t++) begin
            counter_m[t]  = '0;
            reload_m[t]   = '0;
            flag_m[t]     = 1'b0;
            periodic_m[t] = 1'b0;
        end

        directed_rows = '{
            '{OP_CHECK,  3'd0, 32'h0,        1'b0, 1'b1, 1'b0},
            '{OP_CHECK,  3'd7, 32'h0,        1'b1, 1'b1, 1'b0},
            '{OP_START,  3'd0, 32'h0,        1'b0, 1'b0, 1'b0},
            '{OP_TICK,   3'd0, 32'h0,        1'b0, 1'b0, 1'b0},
            '{OP_CHECK,  3'd0, 32'h0,        1'b0, 1'b1, 1'b1},
            '{OP_CHECK,  3'd0, 32'h0,        1'b0, 1'b1, 1'b0},
            '{OP_START,  3'd7, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b0},
            '{OP_START,  3'd1, 32'd2,        1'b1, 1'b0, 1'b0},
            '{OP_TICK,   3'd0, 32'h0,        1'b0, 1'b0, 1'b0},
            '{OP_CHECK,  3'd1, 32'h0,        1'b0, 1'b0, 1'b0},
            '{OP_TICK,   3'd0, 32'h0,        1'b0, 1'b0, 1'b0},
            '{OP_CHECK,  3'd1, 32'h0,        1'b0, 1'b0, 1'b0},
            '{OP_TICK,   3'd0, 32'h0,        1'b0, 1'b0, 1'b0},
            '{OP_CHECK,  3'd1, 32'h0,        1'b0, 1'b0, 1'b0},
            '{OP_TICK,   3'd0, 32'h0,        1'b0, 1'b0, 1'b0},
            '{OP_CHECK,  3'd1, 32'h0,        1'b0, 1'b0, 1'b0},
            '{OP_UNUSED, 3'd5, 32'hA5A5A5A5, 1'b1, 1'b0, 1'b0},
            '{OP_START,  3'd2, 32'd1,        1'b0, 1'b0, 1'b0},
            '{OP_START,  3'd2, 32'd3,        1'b1, 1'b0, 1'b0},
            '{OP_TICK,   3'd0, 32'h0,        1'b0, 1'b0, 1'b0},
            '{OP_CHECK,  3'd2, 32'h0,        1'b0, 1'b0, 1'b0},
            '{OP_START,  3'd3, 32'h5A5A5A5A, 1'b0, 1'b0, 1'b0},
            '{OP_TICK,   3'd0, 32'h0,        1'b0, 1'b0, 1'b0},
            '{OP_CHECK,  3'd3, 32'h0,        1'b0, 1'b0, 1'b0},
            '{OP_CHECK,  3'd7, 32'h0,        1'b0, 1'b1, 1'b0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_cmd(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].period,
                     directed_rows[r].mode, directed_rows[r].typed, directed_rows[r].typed_val);
        end

        // Mostly short periods so that timers expire often; ticks dominate to drive expiry.
        sent = 0;
        while (sent < RANDOM_CMDS) begin
            if (sent == 150) begin
                hold_request = 1'b1;
            end
            calm = (sent >= 400 && sent < 520);
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                op = OP_TICK;
            end else if (roll < 60) begin
                op = OP_START;
            end else if (roll < 95) begin
                op = OP_CHECK;
            end else begin
                op = OP_UNUSED;
            end
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                period = '0;
            end else if (roll < 75) begin
                period = $urandom_range(1, 6);
            end else if (roll < 85) begin
                period = $urandom_range(7, 40);
            end else begin
                period = $urandom;
            end
            send_cmd(op, INDEX_W'($urandom_range(0, NUM_TIMERS - 1)), period,
                     1'($urandom_range(0, 1)), 1'b0, 1'b0);
            if (op != OP_UNUSED) begin
                sent++;
            end
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (expired_due_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (NUM_TIMERS + 12) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> countdown_timer_bank.f
rtl/cdt_pkg.sv
rtl/countdown_timer_bank.sv
tb/tb_countdown_timer_bank.sv
